/* hw/rtl/ccf_pkg.sv */
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types and constants for the cubical coface enumerator.
// ----------------------------------------------------------------------------
package ccf_pkg;

  // Grid store geometry: address is {y, x}
  localparam int unsigned X_W    = 11;
  localparam int unsigned Y_W    = 10;
  localparam int unsigned ADDR_W = X_W + Y_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned CFG_IDX_W = 2;

  // Item modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_ENUM   = 2'd2;

  // Cell dimensions
  localparam logic [1:0] DIM_VERTEX = 2'd0;
  localparam logic [1:0] DIM_EDGE   = 2'd1;
  localparam logic [1:0] DIM_SQUARE = 2'd2;
  localparam logic [1:0] DIM_NONE   = 2'd3;

  // Edge orientation
  localparam logic ORIENT_X = 1'b0;
  localparam logic ORIENT_Y = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [X_W-1:0]          cell_x;
    logic [Y_W-1:0]          cell_y;
    logic [1:0]              cell_dim;
    logic                    edge_orient;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]          out_x;
    logic [Y_W-1:0]          out_y;
    logic [1:0]              out_dim;
    logic                    out_orient;
    logic signed [DATA_W-1:0] birth_out;
    logic                    found;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] threshold;
    logic [X_W-1:0]          grid_width;
    logic [Y_W-1:0]          grid_height;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

/* hw/rtl/ccf_pixel_ram.sv */
// ----------------------------------------------------------------------------
// ccf_pixel_ram
// Single-port pixel store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ccf_pixel_ram
  import ccf_pkg::*;
(
  input  logic                     clk_i,
  input  ram_req_t                 req_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end else if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ccf_engine.sv */
// ----------------------------------------------------------------------------
// ccf_engine
// Sequencer: writes pixels, or reads them, folds births as data returns,
// then emits a lookup result or surviving cofaces, one per res_ready_i cycle.
// ----------------------------------------------------------------------------
module ccf_engine
  import ccf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  input  in_item_t          in_item_i,
  output logic              in_stall_o,
  output logic              res_valid_o,
  output out_item_t         res_item_o,
  input  logic              res_ready_i,
  output ram_req_t          ram_req_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // Pixel offset {dx, dy} (two-bit signed each) for read slot s
  function automatic logic [3:0] read_offset(input logic is_enum, input logic [1:0] dim,
                                             input logic orient, input logic [1:0] s);
    logic [3:0] off;
    off = 4'b0000;
    if (!is_enum) begin
      case (s)
        2'd1:    off = (dim == DIM_EDGE && orient == ORIENT_Y) ? 4'b0001 : 4'b0100;
        2'd2:    off = 4'b0001;
        2'd3:    off = 4'b0101;
        default: off = 4'b0000;
      endcase
    end else if (dim == DIM_VERTEX) begin
      case (s)
        2'd0:    off = 4'b0001;
        2'd1:    off = 4'b0011;
        2'd2:    off = 4'b0100;
        default: off = 4'b1100;
      endcase
    end else if (orient == ORIENT_X) begin
      case (s)
        2'd0:    off = 4'b0001;
        2'd1:    off = 4'b0101;
        2'd2:    off = 4'b0011;
        default: off = 4'b0111;
      endcase
    end else begin
      case (s)
        2'd0:    off = 4'b0100;
        2'd1:    off = 4'b0101;
        2'd2:    off = 4'b1100;
        default: off = 4'b1101;
      endcase
    end
    return off;
  endfunction

  function automatic logic [2:0] read_count(input logic [1:0] mode, input logic [1:0] dim);
    logic [2:0] n;
    n = 3'd0;
    if (mode == MODE_LOOKUP) begin
      case (dim)
        DIM_VERTEX: n = 3'd1;
        DIM_EDGE:   n = 3'd2;
        DIM_SQUARE: n = 3'd4;
        default:    n = 3'd0;
      endcase
    end else if (mode == MODE_ENUM && (dim == DIM_VERTEX || dim == DIM_EDGE)) begin
      n = 3'd4;
    end
    return n;
  endfunction

  logic [1:0]               state_q, state_d;
  in_item_t                 item_q, item_d;
  logic [2:0]               rd_idx_q, rd_idx_d;
  logic [2:0]               rd_cnt_q, rd_cnt_d;
  logic                     pend_q, pend_d;
  logic [1:0]               pend_slot_q, pend_slot_d;
  logic                     pend_oob_q, pend_oob_d;
  logic signed [DATA_W-1:0] bs_q [4];
  logic signed [DATA_W-1:0] bs_d [4];
  logic [3:0]               mask_q, mask_d;

  logic                     accept;
  logic                     is_enum;
  logic [3:0]               off;
  logic [X_W:0]             rd_x;
  logic [Y_W:0]             rd_y;
  logic                     rd_in;
  logic signed [DATA_W-1:0] land_p;
  logic signed [DATA_W-1:0] land_base;
  logic [1:0]               land_t;
  logic                     use_acc;
  logic [1:0]               emit_e;
  logic                     emit_last;
  out_item_t                res;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_enum    = (item_q.mode == MODE_ENUM);

  // Read address for the current slot, with region check
  assign off  = read_offset(is_enum, item_q.cell_dim, item_q.edge_orient, rd_idx_q[1:0]);
  assign rd_x = {1'b0, item_q.cell_x} + {{(X_W - 1){off[3]}}, off[3:2]};
  assign rd_y = {1'b0, item_q.cell_y} + {{(Y_W - 1){off[1]}}, off[1:0]};
  assign rd_in = !rd_x[X_W] && (rd_x[X_W-1:0] != '0) && (rd_x[X_W-1:0] <= cfg_i.grid_width)
              && !rd_y[Y_W] && (rd_y[Y_W-1:0] != '0) && (rd_y[Y_W-1:0] <= cfg_i.grid_height);

  // Fold a returning pixel into its coface birth
  assign land_p  = pend_oob_q ? cfg_i.threshold : $signed(ram_rdata_i);
  always_comb begin
    if (!is_enum) begin
      land_t  = 2'd0;
      use_acc = (pend_slot_q != 2'd0);
    end else if (item_q.cell_dim == DIM_VERTEX) begin
      land_t  = pend_slot_q;
      use_acc = 1'b0;
    end else begin
      land_t  = {1'b0, pend_slot_q[1]};
      use_acc = pend_slot_q[0];
    end
  end
  assign land_base = use_acc ? bs_q[land_t] : (is_enum ? item_q.value_in : land_p);

  assign emit_e    = mask_q[0] ? 2'd0 : mask_q[1] ? 2'd1 : mask_q[2] ? 2'd2 : 2'd3;
  assign emit_last = ((mask_q & (mask_q - 4'd1)) == 4'd0);

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (!is_enum) begin
      res.out_x      = item_q.cell_x;
      res.out_y      = item_q.cell_y;
      res.out_dim    = item_q.cell_dim;
      res.out_orient = item_q.edge_orient;
      res.found      = (item_q.cell_dim != DIM_NONE);
      res.birth_out  = res.found ? bs_q[0] : cfg_i.threshold;
    end else if (mask_q != 4'd0) begin
      res.out_x     = item_q.cell_x;
      res.out_y     = item_q.cell_y;
      res.found     = 1'b1;
      res.last      = emit_last;
      res.birth_out = bs_q[emit_e];
      if (item_q.cell_dim == DIM_VERTEX) begin
        res.out_dim    = DIM_EDGE;
        res.out_orient = (emit_e < 2'd2) ? ORIENT_Y : ORIENT_X;
        if (emit_e == 2'd1) res.out_y = item_q.cell_y - Y_W'(1);
        if (emit_e == 2'd3) res.out_x = item_q.cell_x - X_W'(1);
      end else begin
        res.out_dim    = DIM_SQUARE;
        res.out_orient = ORIENT_X;
        if (emit_e == 2'd1) begin
          if (item_q.edge_orient == ORIENT_X) res.out_y = item_q.cell_y - Y_W'(1);
          else                                res.out_x = item_q.cell_x - X_W'(1);
        end
      end
    end
  end

  assign res_item_o  = res;
  assign res_valid_o = (state_q == ST_EMIT);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    rd_idx_d    = rd_idx_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = 1'b0;
    pend_slot_d = pend_slot_q;
    pend_oob_d  = pend_oob_q;
    bs_d        = bs_q;
    mask_d      = mask_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.re    = 1'b0;
    ram_req_o.addr  = {rd_y[Y_W-1:0], rd_x[X_W-1:0]};
    ram_req_o.wdata = in_item_i.value_in;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d   = in_item_i;
          rd_idx_d = 3'd0;
          rd_cnt_d = read_count(in_item_i.mode, in_item_i.cell_dim);
          if (in_item_i.mode == MODE_WRITE) begin
            ram_req_o.we   = 1'b1;
            ram_req_o.addr = {in_item_i.cell_y, in_item_i.cell_x};
          end else if (in_item_i.mode == MODE_LOOKUP || in_item_i.mode == MODE_ENUM) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (pend_q) begin
          bs_d[land_t] = (land_p > land_base) ? land_p : land_base;
        end
        if (rd_idx_q != rd_cnt_q) begin
          ram_req_o.re = rd_in;
          pend_d       = 1'b1;
          pend_slot_d  = rd_idx_q[1:0];
          pend_oob_d   = !rd_in;
          rd_idx_d     = rd_idx_q + 3'd1;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!is_enum) begin
          mask_d = 4'b0001;
        end else if (item_q.cell_dim == DIM_VERTEX) begin
          for (int i = 0; i < 4; i++) mask_d[i] = (bs_q[i] != cfg_i.threshold);
        end else if (item_q.cell_dim == DIM_EDGE) begin
          mask_d = {2'b00, bs_q[1] != cfg_i.threshold, bs_q[0] != cfg_i.threshold};
        end else begin
          mask_d = 4'b0000;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          mask_d = mask_q & (mask_q - 4'd1);
          if (!is_enum || emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= 1'b0;
      rd_idx_q <= 3'd0;
      rd_cnt_q <= 3'd0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      rd_idx_q <= rd_idx_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pend_slot_q <= pend_slot_d;
    pend_oob_q  <= pend_oob_d;
    bs_q        <= bs_d;
    mask_q      <= mask_d;
  end

endmodule

/* hw/rtl/cubical_coface_enumerator.sv */
// ----------------------------------------------------------------------------
// cubical_coface_enumerator
// Pixel grid store with cell birth lookup and coface enumeration.
// ----------------------------------------------------------------------------
// A pixel write is done in the cycle it is accepted. A lookup or
// enumeration stalls the input while it makes its n pixel reads (n is 0
// to 4), evaluates and hands on its results; all reads go one per cycle
// through the single port of the pixel store. Results leave through an
// output register, so the next item is taken while the last result waits.
// Configuration writes are always accepted; the user must make them only
// between items to apply to the next item; the block does not check this.
module cubical_coface_enumerator
  import ccf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  cfg_t              cfg_q;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;
  logic              out_valid_q;
  out_item_t         out_item_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= 32'sh7fffffff;
      cfg_q.grid_width  <= 11'd2046;
      cfg_q.grid_height <= 10'd1022;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   cfg_q.threshold   <= $signed(cfg_data_i);
        CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data_i[X_W-1:0];
        CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_data_i[Y_W-1:0];
        default: ;
      endcase
    end
  end

  ccf_pixel_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  ccf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_ready_i (res_ready),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: refill in the same cycle as a transfer
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
